// ===== rtl/hdsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the delta sample unpacker.
// No dependencies; imported by the unpacker top level.
package hdsu_pkg;

  localparam int TREE_NODES_DEF = 256;
  localparam int COUNT_BITS_DEF = 24;

  localparam int VAL_W    = 7;
  localparam int LINK_W   = 9;
  localparam int SAMPLE_W = 8;
  localparam int HDR_W    = 9;
  localparam int HCNT_W   = 4;

  localparam logic [LINK_W-1:0]   CHILD_NONE = 9'h1FF;
  localparam logic [HCNT_W-1:0]   HDR_LAST   = 4'd8;
  localparam logic [2:0]          BIT_LAST   = 3'd7;
  localparam logic [SAMPLE_W-1:0] INV_MASK   = 8'hFF;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SIGN,
    PH_WALK,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_ROOT,
    ST_WALK,
    ST_POP,
    ST_POP_WR
  } state_e;

  typedef struct packed {
    logic [LINK_W-1:0] right;
    logic [LINK_W-1:0] left;
    logic [VAL_W-1:0]  value;
  } tree_node_t;

endpackage

// ===== rtl/hdsu_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hdsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/huffman_delta_sample_unpacker.sv =====
`timescale 1ns / 1ps
// Delta sample unpacker: rebuilds a code tree from a preorder bit header, then
// walks it per sample. Depends on hdsu_pkg and hdsu_ram.

// Usage: bytes arrive on the in channel one beat at a time and are consumed
// least significant bit first. A beat with start_block set clears the tree and
// all counters and begins a new block; sample_count (written on the cfg
// channel while idle) sets how many samples a block yields. Samples leave on
// the out channel through a one-entry output register, so the next byte is
// taken while a sample still waits there. Each byte is accepted in ST_IDLE and
// then handled bit by bit: a header bit in ST_BIT, a sign bit in ST_BIT then
// ST_ROOT (root node read) and a walk bit in ST_BIT then ST_WALK (child node
// read from the registered tree memory, when the link is in range). A node
// header that closes a subtree adds a stack memory read (ST_POP) and a tree
// write (ST_POP_WR) for each entry popped off the pending stack. A finished
// sample waits while the out channel stalls with its register still full. Tree
// and pending stack each live in a synchronous RAM; per-node valid flops make
// a block start clear the tree at once, with no sweep.
module huffman_delta_sample_unpacker
  import hdsu_pkg::*;
#(
  parameter int TREE_NODES = TREE_NODES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [COUNT_BITS-1:0] cfg_data_i,
  // input byte channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  start_block_i,
  input  logic                  is_final_i,
  input  logic                  is_pad_i,
  // sample channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SAMPLE_W-1:0]   sample_o,
  output logic [COUNT_BITS-1:0] sample_index_o,
  output logic                  last_sample_o,
  output logic [COUNT_BITS-1:0] bytes_used_o
);

  localparam int AW    = $clog2(TREE_NODES);
  localparam int NCW   = $clog2(TREE_NODES + 1);
  localparam int STK_W = VAL_W + 1 + AW;

  localparam logic [NCW-1:0]    NC_FULL   = NCW'(TREE_NODES);
  localparam logic [LINK_W-1:0] LINK_FULL = LINK_W'(TREE_NODES);

  // Control state
  state_e                state_q, state_d;
  phase_e                phase_q, phase_d;
  logic [2:0]            bit_q, bit_d;
  logic [HDR_W-1:0]      header_bits_q, header_bits_d;
  logic [HCNT_W-1:0]     header_count_q, header_count_d;
  logic [NCW-1:0]        node_count_q, node_count_d;
  logic [NCW-1:0]        depth_q, depth_d;
  logic                  sign_q, sign_d;
  logic [SAMPLE_W-1:0]   delta_q, delta_d;
  logic [SAMPLE_W-1:0]   running_q, running_d;
  logic [COUNT_BITS-1:0] samples_done_q, samples_done_d;
  logic [COUNT_BITS-1:0] bytes_q, bytes_d;
  logic                  input_ended_q, input_ended_d;
  logic [COUNT_BITS-1:0] sample_count_q;
  logic [TREE_NODES-1:0] valid_q;
  logic                  rd_valid_q;

  // Payload state
  logic [7:0]            data_q, data_d;
  logic [LINK_W-1:0]     cur_left_q, cur_left_d;
  logic [LINK_W-1:0]     cur_right_q, cur_right_d;

  // Output register
  logic                  out_valid_q;
  logic [SAMPLE_W-1:0]   out_sample_q;
  logic [COUNT_BITS-1:0] out_index_q;
  logic                  out_last_q;
  logic [COUNT_BITS-1:0] out_bytes_q;

  // Memory ports
  logic              tree_we, tree_re;
  logic [AW-1:0]     tree_waddr, tree_raddr;
  tree_node_t        tree_wdata;
  logic [$bits(tree_node_t)-1:0] tree_rdata;
  logic              stk_we, stk_re;
  logic [AW-1:0]     stk_waddr, stk_raddr;
  logic [STK_W-1:0]  stk_wdata, stk_rdata;

  // Decode
  logic                  in_accept;
  logic                  clear_blk;
  logic                  real_byte;
  logic                  bit_v;
  logic [HDR_W-1:0]      hb_new;
  logic                  hdr_last;
  logic [NCW-1:0]        nc1;
  logic                  nc1_ok, nc_ok;
  logic [LINK_W-1:0]     child;
  logic                  child_in;
  tree_node_t            rnode;
  logic                  walk_cont;
  logic                  out_free;
  logic [SAMPLE_W-1:0]   fin_delta;
  logic [SAMPLE_W-1:0]   run_new;
  logic [COUNT_BITS-1:0] sd1;
  logic                  last_w;
  logic                  sd_reached, sd1_reached;
  logic [NCW-1:0]        depth_m1;
  logic [AW-1:0]         pop_n;
  logic                  pop_isr;
  logic [VAL_W-1:0]      pop_val;
  logic                  advance;
  logic                  emit;

  hdsu_ram #(
    .WIDTH ($bits(tree_node_t)),
    .DEPTH (TREE_NODES)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (tree_we),
    .waddr_i (tree_waddr),
    .wdata_i (tree_wdata),
    .re_i    (tree_re),
    .raddr_i (tree_raddr),
    .rdata_o (tree_rdata)
  );

  hdsu_ram #(
    .WIDTH (STK_W),
    .DEPTH (TREE_NODES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign clear_blk   = in_accept && start_block_i;
  // bytes after the final one are pad, pad wins over final
  assign real_byte   = !is_pad_i && !(input_ended_q && !start_block_i);

  assign bit_v    = data_q[bit_q];
  assign hdr_last = (header_count_q == HDR_LAST);
  always_comb begin
    hb_new                 = header_bits_q;
    hb_new[header_count_q] = header_bits_q[header_count_q] | bit_v;
  end

  assign nc1    = node_count_q + NCW'(1);
  assign nc1_ok = (nc1 < NC_FULL);
  assign nc_ok  = (node_count_q < NC_FULL);

  // Walk: the current node's links sit in cur_*, the child comes from the RAM.
  // Unwritten nodes read as zero.
  assign child     = bit_v ? cur_right_q : cur_left_q;
  assign child_in  = (child < LINK_FULL);
  assign rnode     = rd_valid_q ? tree_node_t'(tree_rdata) : '0;
  assign walk_cont = !(input_ended_q && (bit_q == BIT_LAST)) &&
                     (rnode.left != CHILD_NONE) && (rnode.right != CHILD_NONE);

  // Sample finish; a full tree keeps the previous delta
  assign out_free  = !out_valid_q || out_ready_i;
  assign fin_delta = ((state_q == ST_WALK) ? {1'b0, rnode.value} : delta_q) ^
                     (sign_q ? INV_MASK : '0);
  assign run_new   = running_q + fin_delta;
  assign sd1       = samples_done_q + COUNT_BITS'(1);
  assign last_w    = ({1'b0, samples_done_q} + (COUNT_BITS+1)'(1)) >= {1'b0, sample_count_q};
  assign sd_reached  = (samples_done_q >= sample_count_q);
  assign sd1_reached = (sd1 >= sample_count_q);

  assign depth_m1 = depth_q - NCW'(1);
  assign pop_n    = stk_rdata[AW-1:0];
  assign pop_isr  = stk_rdata[AW];
  assign pop_val  = stk_rdata[STK_W-1:AW+1];

  // Next state
  always_comb begin
    state_d = state_q;
    advance = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_BIT;
        end
      end
      ST_BIT: begin
        unique case (phase_q)
          PH_DONE: state_d = ST_IDLE;
          PH_HEADER: begin
            if (!hdr_last) begin
              advance = 1'b1;
            end else if ((hb_new[7] || hb_new[8]) && nc1_ok) begin
              advance = 1'b1;
            end else begin
              state_d = ST_POP;
            end
          end
          PH_SIGN: state_d = ST_ROOT;
          PH_WALK: begin
            if (child_in) begin
              state_d = ST_WALK;
            end else if (out_free) begin
              advance = 1'b1;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_ROOT: advance = 1'b1;
      ST_WALK: begin
        if (walk_cont || out_free) begin
          advance = 1'b1;
        end
      end
      ST_POP: begin
        if (depth_q != '0) begin
          state_d = ST_POP_WR;
        end else begin
          advance = 1'b1;
        end
      end
      ST_POP_WR: begin
        if (pop_isr && nc_ok) begin
          advance = 1'b1;
        end else begin
          state_d = ST_POP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (advance) begin
      state_d = (bit_q == BIT_LAST) ? ST_IDLE : ST_BIT;
    end
  end

  // Datapath and memory control
  always_comb begin
    phase_d        = phase_q;
    bit_d          = advance ? bit_q + 3'd1 : bit_q;
    header_bits_d  = header_bits_q;
    header_count_d = header_count_q;
    node_count_d   = node_count_q;
    depth_d        = depth_q;
    sign_d         = sign_q;
    delta_d        = delta_q;
    running_d      = running_q;
    samples_done_d = samples_done_q;
    bytes_d        = bytes_q;
    input_ended_d  = input_ended_q;
    data_d         = data_q;
    cur_left_d     = cur_left_q;
    cur_right_d    = cur_right_q;
    tree_we        = 1'b0;
    tree_waddr     = node_count_q[AW-1:0];
    tree_wdata     = '0;
    tree_re        = 1'b0;
    tree_raddr     = '0;
    stk_we         = 1'b0;
    stk_waddr      = depth_q[AW-1:0];
    stk_wdata      = {hb_new[VAL_W-1:0], hb_new[8], node_count_q[AW-1:0]};
    stk_re         = 1'b0;
    stk_raddr      = depth_m1[AW-1:0];
    emit           = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          bit_d = '0;
          if (start_block_i) begin
            phase_d        = PH_HEADER;
            header_bits_d  = '0;
            header_count_d = '0;
            node_count_d   = '0;
            depth_d        = '0;
            sign_d         = 1'b0;
            delta_d        = '0;
            running_d      = '0;
            samples_done_d = '0;
          end
          input_ended_d = (input_ended_q && !start_block_i) || is_pad_i || is_final_i;
          data_d        = real_byte ? data_byte_i : '0;
          // count a real byte once, unless the block is already finished
          bytes_d = (start_block_i ? '0 : bytes_q) +
                    COUNT_BITS'(real_byte && (start_block_i || phase_q != PH_DONE));
        end
      end
      ST_BIT: begin
        unique case (phase_q)
          PH_DONE: ;
          PH_HEADER: begin
            if (!hdr_last) begin
              header_bits_d  = hb_new;
              header_count_d = header_count_q + HCNT_W'(1);
            end else begin
              node_count_d     = nc1;
              tree_we          = 1'b1;
              tree_wdata.value = hb_new[VAL_W-1:0];
              if (hb_new[7]) begin
                // right link is filled in when this entry pops
                tree_wdata.left  = LINK_W'(nc1);
                tree_wdata.right = '0;
                stk_we           = 1'b1;
                depth_d          = depth_q + NCW'(1);
              end else begin
                tree_wdata.left  = CHILD_NONE;
                tree_wdata.right = hb_new[8] ? LINK_W'(nc1) : CHILD_NONE;
              end
              if ((hb_new[7] || hb_new[8]) && nc1_ok) begin
                header_bits_d  = '0;
                header_count_d = '0;
              end
            end
          end
          PH_SIGN: begin
            sign_d     = bit_v;
            phase_d    = PH_WALK;
            tree_re    = 1'b1;
            tree_raddr = '0;
          end
          PH_WALK: begin
            if (child_in) begin
              tree_re    = 1'b1;
              tree_raddr = child[AW-1:0];
            end else if (out_free) begin
              emit = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_ROOT: begin
        cur_left_d  = rnode.left;
        cur_right_d = rnode.right;
      end
      ST_WALK: begin
        if (walk_cont) begin
          cur_left_d  = rnode.left;
          cur_right_d = rnode.right;
          delta_d     = {1'b0, rnode.value};
        end else if (out_free) begin
          emit = 1'b1;
        end
      end
      ST_POP: begin
        if (depth_q != '0) begin
          depth_d = depth_m1;
          stk_re  = 1'b1;
        end else begin
          phase_d = sd_reached ? PH_DONE : PH_SIGN;
        end
      end
      ST_POP_WR: begin
        tree_we          = 1'b1;
        tree_waddr       = pop_n;
        tree_wdata.value = pop_val;
        tree_wdata.left  = LINK_W'(pop_n) + LINK_W'(1);
        tree_wdata.right = pop_isr ? LINK_W'(node_count_q) : CHILD_NONE;
        if (pop_isr && nc_ok) begin
          phase_d        = PH_HEADER;
          header_bits_d  = '0;
          header_count_d = '0;
        end
      end
      default: ;
    endcase

    if (emit) begin
      delta_d        = fin_delta;
      running_d      = run_new;
      samples_done_d = sd1;
      phase_d        = sd1_reached ? PH_DONE : PH_SIGN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      phase_q        <= PH_HEADER;
      bit_q          <= '0;
      header_bits_q  <= '0;
      header_count_q <= '0;
      node_count_q   <= '0;
      depth_q        <= '0;
      sign_q         <= 1'b0;
      delta_q        <= '0;
      running_q      <= '0;
      samples_done_q <= '0;
      bytes_q        <= '0;
      input_ended_q  <= 1'b0;
      sample_count_q <= '0;
      valid_q        <= '0;
      rd_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      phase_q        <= phase_d;
      bit_q          <= bit_d;
      header_bits_q  <= header_bits_d;
      header_count_q <= header_count_d;
      node_count_q   <= node_count_d;
      depth_q        <= depth_d;
      sign_q         <= sign_d;
      delta_q        <= delta_d;
      running_q      <= running_d;
      samples_done_q <= samples_done_d;
      bytes_q        <= bytes_d;
      input_ended_q  <= input_ended_d;
      if (cfg_valid_i && cfg_ready_o) begin
        sample_count_q <= cfg_data_i;
      end
      // drop the whole tree on block start, mark nodes as they are written
      if (clear_blk) begin
        valid_q <= '0;
      end else if (tree_we) begin
        valid_q[tree_waddr] <= 1'b1;
      end
      if (tree_re) begin
        rd_valid_q <= valid_q[tree_raddr];
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q      <= data_d;
    cur_left_q  <= cur_left_d;
    cur_right_q <= cur_right_d;
    if (emit) begin
      out_sample_q <= (samples_done_q != '0) ? run_new : '0;
      out_index_q  <= samples_done_q;
      out_last_q   <= last_w;
      out_bytes_q  <= last_w ? bytes_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = out_sample_q;
  assign sample_index_o = out_index_q;
  assign last_sample_o  = out_last_q;
  assign bytes_used_o   = out_bytes_q;

  // Build and walk never touch the tree in the same cycle
  a_tree_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tree_we && tree_re))
    else $error("tree read and write in the same cycle");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q <= node_count_q) && (node_count_q <= NC_FULL))
    else $error("pending stack deeper than node count");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("sample overwrote an untaken beat");

  a_header_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEADER) |-> (header_count_q <= HDR_LAST))
    else $error("header bit count out of range");

  a_pop_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_WR) |-> $past(stk_re))
    else $error("stack write-back without a stack read");

endmodule

// ===== verif/huffman_delta_sample_unpacker_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the delta sample unpacker: directed and random byte streams,
// a local decoder that predicts every sample beat. Depends on hdsu_pkg and the unpacker RTL.
module huffman_delta_sample_unpacker_test;
  import hdsu_pkg::*;

  localparam int NODES        = TREE_NODES_DEF;
  localparam int CW           = COUNT_BITS_DEF;
  // Longest quiet spell of a correct run: one byte whose last header pops the whole
  // pending stack. Allow well over that.
  localparam int QUIET_CYCLES = 1200;
  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_BEATS = 370;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          cfg_valid_i   = 1'b0;
  logic          cfg_ready_o;
  logic [CW-1:0] cfg_data_i    = '0;
  logic          in_valid_i    = 1'b0;
  logic          in_ready_o;
  logic [7:0]    data_byte_i   = '0;
  logic          start_block_i = 1'b0;
  logic          is_final_i    = 1'b0;
  logic          is_pad_i      = 1'b0;
  logic          out_valid_o;
  logic          out_ready_i   = 1'b0;
  logic [SAMPLE_W-1:0] sample_o;
  logic [CW-1:0] sample_index_o;
  logic          last_sample_o;
  logic [CW-1:0] bytes_used_o;

  always #2 clk_i = ~clk_i;

  huffman_delta_sample_unpacker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .start_block_i (start_block_i),
    .is_final_i    (is_final_i),
    .is_pad_i      (is_pad_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_o      (sample_o),
    .sample_index_o(sample_index_o),
    .last_sample_o (last_sample_o),
    .bytes_used_o  (bytes_used_o)
  );

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic [CW-1:0]       index;
    logic                is_last;
    logic [CW-1:0]       used;
  } sample_beat_t;

  sample_beat_t pending_samples[$];   // predicted beats, oldest first
  bit           stream_bits[$];       // bit stream under construction, LSB of first byte first

  int fail_count   = 0;
  int beat_total   = 0;
  int sample_total = 0;
  int cfg_total    = 0;
  int stall_cycles = 0;
  bit steady       = 1'b0;            // high: neither side idles

  // Handshake flags and output fields, captured at the falling edge. Inputs only move
  // at the rising edge, so these hold the values seen by the next rising edge.
  bit                  in_take, cfg_take, out_take;
  logic [SAMPLE_W-1:0] seen_value;
  logic [CW-1:0]       seen_index, seen_used;
  logic                seen_last;

  always @(negedge clk_i) begin
    in_take    = rst_ni && in_valid_i && in_ready_o;
    cfg_take   = rst_ni && cfg_valid_i && cfg_ready_o;
    out_take   = rst_ni && out_valid_o && out_ready_i;
    seen_value = sample_o;
    seen_index = sample_index_o;
    seen_last  = last_sample_o;
    seen_used  = bytes_used_o;
  end

  // ---------------------------------------------------------------------------
  // Decoder state for prediction
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0]  tn_val   [NODES];
  logic [LINK_W-1:0] tn_left  [NODES];
  logic [LINK_W-1:0] tn_right [NODES];
  logic [LINK_W-1:0] pend_stack[NODES];  // {parent node, right child still to come}
  int unsigned       pend_depth, built_nodes, hdr_cnt, walk_at;
  phase_e            dec_phase;
  logic [HDR_W-1:0]  hdr_bits;
  logic              sign_q, ended_q;
  logic [7:0]        delta_q, sum_q;
  logic [CW-1:0]     done_q, loaded_q, count_reg;

  function automatic logic [VAL_W-1:0] val_of(int unsigned n);
    return (n < NODES) ? tn_val[n] : '0;
  endfunction

  function automatic logic [LINK_W-1:0] left_of(int unsigned n);
    return (n < NODES) ? tn_left[n] : CHILD_NONE;
  endfunction

  function automatic logic [LINK_W-1:0] right_of(int unsigned n);
    return (n < NODES) ? tn_right[n] : CHILD_NONE;
  endfunction

  // Stop before a sample once the configured count is reached.
  function automatic void next_sample();
    if (done_q >= count_reg) dec_phase = PH_DONE;
    else dec_phase = PH_SIGN;
  endfunction

  // Begin a node header; refuse once the tree is full.
  function automatic bit open_node();
    if (built_nodes >= NODES) return 1'b0;
    dec_phase = PH_HEADER;
    hdr_cnt   = 0;
    hdr_bits  = '0;
    return 1'b1;
  endfunction

  // Pop parents until one still owes a right subtree, or the tree is complete.
  function automatic void unwind_stack();
    logic [LINK_W-1:0] e;
    while (1) begin
      if (pend_depth == 0) begin
        next_sample();
        return;
      end
      pend_depth--;
      e = pend_stack[pend_depth % NODES];
      if (e[0]) begin
        tn_right[e[8:1]] = LINK_W'(built_nodes);
        if (open_node()) return;
      end else begin
        tn_right[e[8:1]] = CHILD_NONE;
      end
    end
  endfunction

  function automatic void finish_header();
    int unsigned n;
    n = built_nodes;
    tn_val[n] = hdr_bits[VAL_W-1:0];
    built_nodes++;
    if (hdr_bits[7]) begin
      tn_left[n] = LINK_W'(built_nodes);
      if (pend_depth < NODES) begin
        pend_stack[pend_depth] = {n[7:0], hdr_bits[8]};
        pend_depth++;
      end
      if (!open_node()) unwind_stack();
      return;
    end
    tn_left[n] = CHILD_NONE;
    if (hdr_bits[8]) begin
      tn_right[n] = LINK_W'(built_nodes);
      if (open_node()) return;
    end else begin
      tn_right[n] = CHILD_NONE;
    end
    unwind_stack();
  endfunction

  function automatic void clear_block();
    for (int i = 0; i < NODES; i++) begin
      tn_val[i]     = '0;
      tn_left[i]    = '0;
      tn_right[i]   = '0;
      pend_stack[i] = '0;
    end
    pend_depth  = 0;
    built_nodes = 0;
    walk_at     = 0;
    sign_q      = 1'b0;
    delta_q     = '0;
    sum_q       = '0;
    done_q      = '0;
    loaded_q    = '0;
    ended_q     = 1'b0;
    void'(open_node());
  endfunction

  // Advance the decoder over one accepted byte and queue the samples it completes.
  function automatic void unpack_byte(logic [7:0] d, logic sb, logic fin, logic pad);
    logic [7:0]        bits;
    logic [LINK_W-1:0] child;
    bit                real_b, counted, walk_ends;
    sample_beat_t      beat;
    counted = 1'b0;
    if (sb) clear_block();
    real_b = !pad && !ended_q;
    if (pad || fin) ended_q = 1'b1;
    bits = real_b ? d : 8'h00;
    for (int b = 0; b < 8; b++) begin
      if (dec_phase == PH_DONE) break;
      if (!counted) begin
        counted = 1'b1;
        if (real_b) loaded_q++;
      end
      case (dec_phase)
        PH_HEADER: begin
          hdr_bits[hdr_cnt] = bits[b];
          hdr_cnt++;
          if (hdr_cnt >= HDR_W) finish_header();
        end
        PH_SIGN: begin
          sign_q    = bits[b];
          walk_at   = 0;
          dec_phase = PH_WALK;
        end
        default: begin
          child     = bits[b] ? right_of(walk_at) : left_of(walk_at);
          walk_ends = 1'b1;
          // A link to the slot past a full tree keeps the previous delta.
          if (child < NODES) begin
            delta_q = {1'b0, val_of(child)};
            if (!(ended_q && b == 7) && left_of(child) != CHILD_NONE &&
                right_of(child) != CHILD_NONE) begin
              walk_at   = child;
              walk_ends = 1'b0;
            end
          end
          if (walk_ends) begin
            if (sign_q) delta_q ^= INV_MASK;
            sum_q += delta_q;
            beat.is_last = ({1'b0, done_q} + 1) >= {1'b0, count_reg};
            beat.value   = (done_q != 0) ? sum_q : '0;
            beat.index   = done_q;
            beat.used    = beat.is_last ? loaded_q : '0;
            pending_samples.push_back(beat);
            done_q++;
            next_sample();
          end
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sample checker, receiver idling and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sample_beat_t want;
    if (out_take) begin
      if (pending_samples.size() == 0) begin
        fail_count++;
        $display("%0t: sample beat with nothing expected: value %h index %0d last %b",
                 $time, seen_value, seen_index, seen_last);
      end else begin
        want = pending_samples.pop_front();
        sample_total++;
        if (want.value !== seen_value) begin
          fail_count++;
          $display("%0t: sample %0d value: expected %h, actual %h",
                   $time, want.index, want.value, seen_value);
        end
        if (want.index !== seen_index) begin
          fail_count++;
          $display("%0t: sample index: expected %0d, actual %0d",
                   $time, want.index, seen_index);
        end
        if (want.is_last !== seen_last) begin
          fail_count++;
          $display("%0t: sample %0d last flag: expected %b, actual %b",
                   $time, want.index, want.is_last, seen_last);
        end
        if (want.used !== seen_used) begin
          fail_count++;
          $display("%0t: sample %0d bytes used: expected %0d, actual %0d",
                   $time, want.index, want.used, seen_used);
        end
      end
    end
  end

  // Drop ready at random, with a 22 percent chance, except during the steady stretch.
  always @(posedge clk_i) out_ready_i <= steady || ($urandom_range(99) >= 22);

  // End the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (in_take || out_take || cfg_take) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles, %0d samples still expected",
               $time, stall_cycles, pending_samples.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Send one byte beat; idle first at random. Valid stays high after the accept so that
  // a back-to-back beat never lowers and raises it in one step; drain_samples drops it.
  task automatic send_byte(logic [7:0] d, logic sb, logic fin, logic pad);
    if (!steady) begin
      while ($urandom_range(99) < 22) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= d;
    start_block_i <= sb;
    is_final_i    <= fin;
    is_pad_i      <= pad;
    do @(posedge clk_i); while (!in_take);
    beat_total++;
    unpack_byte(d, sb, fin, pad);
  endtask

  // Release the byte channel, wait out every predicted sample, then let the block settle.
  task automatic drain_samples();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Write sample_count; only called while the block is idle.
  task automatic load_sample_count(logic [CW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_take);
    cfg_valid_i <= 1'b0;
    count_reg = v;
    cfg_total++;
  endtask

  function automatic void put_bits(logic [7:0] v, int n);
    for (int i = 0; i < n; i++) stream_bits.push_back(v[i]);
  endfunction

  function automatic void add_random_bits(int n);
    for (int i = 0; i < n; i++) stream_bits.push_back(1'($urandom));
  endfunction

  // Append a preorder tree header with random values. In fill mode the tree never closes
  // before NODES nodes, so the header stops with children still owed.
  function automatic void add_tree(int max_nodes, bit fill);
    int made, open, k;
    bit l, r;
    made = 0;
    open = 1;
    while (open > 0 && made < NODES) begin
      put_bits(8'($urandom), VAL_W);
      // Favor full nodes so walks reach past the root.
      k = $urandom_range(9);
      l = (k < 5) || (k == 7);
      r = (k < 5) || (k == 8);
      if (fill) begin
        if (open == 1 && !l && !r) l = 1'b1;
      end else if (made + open + l + r > max_nodes) begin
        l = 1'b0;
        r = 1'b0;
      end
      put_bits({6'd0, r, l}, 2);
      made++;
      open = open + l + r - 1;
    end
  endfunction

  // Pack the built stream into bytes, first one starting a block; fill the tail at random.
  task automatic send_stream(bit fin_last);
    int nb;
    logic [7:0] d;
    nb = (stream_bits.size() + 7) / 8;
    for (int k = 0; k < nb; k++) begin
      for (int i = 0; i < 8; i++)
        d[i] = (k * 8 + i < stream_bits.size()) ? stream_bits[k * 8 + i] : 1'($urandom);
      send_byte(d, k == 0, fin_last && k == nb - 1, 1'b0);
    end
    stream_bits.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Out of reset the count is zero: the header still builds, but no sample may appear.
  task automatic test_count_zero();
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    drain_samples();
  endtask

  // Root with two leaves at the value extremes, both signs, both directions; then bytes
  // after the block has finished, which must be ignored.
  task automatic test_small_tree();
    load_sample_count(CW'(4));
    put_bits(8'h55, VAL_W); put_bits(8'h03, 2);
    put_bits(8'h7F, VAL_W); put_bits(8'h00, 2);
    put_bits(8'h00, VAL_W); put_bits(8'h00, 2);
    put_bits(8'h00, 2);   // sign 0, left
    put_bits(8'h03, 2);   // sign 1, right
    put_bits(8'h01, 2);   // sign 1, left
    put_bits(8'h02, 2);   // sign 0, right
    send_stream(1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1, 1'b0);
    drain_samples();
  endtask

  // Deep walks into the end of the buffer: final byte, a real byte after it, pads; then a
  // block opened by a beat that is pad and final at once.
  task automatic test_end_of_input();
    load_sample_count(CW'(12));
    put_bits(8'h11, VAL_W); put_bits(8'h03, 2);
    put_bits(8'h22, VAL_W); put_bits(8'h03, 2);
    put_bits(8'h33, VAL_W); put_bits(8'h00, 2);
    put_bits(8'h44, VAL_W); put_bits(8'h00, 2);
    put_bits(8'h7F, VAL_W); put_bits(8'h00, 2);
    add_random_bits(28);
    send_stream(1'b1);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0, 1'b0);
    drain_samples();
  endtask

  // Fill all tree slots so that some links point past the end of the tree.
  task automatic test_tree_full();
    load_sample_count(CW'(60));
    add_tree(NODES, 1'b1);
    add_random_bits(200);
    send_stream(1'b0);
    drain_samples();
  endtask

  // Lower the count below the samples already done while a block is open, then run a
  // block with the largest count, which never reaches its last sample.
  task automatic test_count_change();
    load_sample_count(CW'(12));
    add_tree(6, 1'b0);
    add_random_bits(27);
    send_stream(1'b0);
    drain_samples();
    load_sample_count(CW'(1));
    send_byte(8'($urandom), 1'b0, 1'b0, 1'b0);
    send_byte(8'($urandom), 1'b0, 1'b0, 1'b0);
    drain_samples();
    load_sample_count({CW{1'b1}});
    add_tree(10, 1'b0);
    add_random_bits(48);
    send_stream(1'b1);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    drain_samples();
  endtask

  // One random block: mostly a well-formed tree with random sample bits, the rest noise.
  task automatic random_block();
    int kind;
    kind = $urandom_range(99);
    if (kind < 80) begin
      add_tree($urandom_range(24, 1), 1'b0);
      add_random_bits(8 * $urandom_range(10, 1));
      if ($urandom_range(99) < 40) begin
        send_stream(1'b1);
        // Tail past the buffer end: pads, stray real bytes, pad with final.
        repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0, 1'($urandom), 1'($urandom));
      end else begin
        send_stream(1'b0);
      end
    end else begin
      // Broken stream: random bytes and flags, often continuing the previous block.
      repeat ($urandom_range(6, 1))
        send_byte(8'($urandom), $urandom_range(99) < 25, $urandom_range(99) < 15,
                  $urandom_range(99) < 15);
    end
  endtask

  task automatic test_random();
    int goal, pick, round;
    logic [CW-1:0] cnt;
    goal  = beat_total + RANDOM_BEATS;
    round = 0;
    while (beat_total < goal) begin
      pick = $urandom_range(99);
      if (pick < 6) cnt = '0;
      else if (pick < 12) cnt = {CW{1'b1}};
      else if (pick < 18) cnt = CW'($urandom);
      else cnt = CW'($urandom_range(12, 1));
      load_sample_count(cnt);
      // Hold both sides busy for one whole round.
      steady = (round == 3);
      repeat ($urandom_range(5, 2)) random_block();
      drain_samples();
      round++;
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    count_reg = '0;
    clear_block();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_count_zero();
    test_small_tree();
    test_end_of_input();
    test_tree_full();
    test_count_change();
    test_random();
    $display("Run covered %0d byte beats, %0d register writes and %0d checked samples,",
             beat_total, cfg_total, sample_total);
    $display("including a full tree, buffer end with pads, and count changes mid-block.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== huffman_delta_sample_unpacker.f =====
rtl/hdsu_pkg.sv
rtl/hdsu_ram.sv
rtl/huffman_delta_sample_unpacker.sv
verif/huffman_delta_sample_unpacker_test.sv
